@@ design/e2q_pkg.sv @@
// Shared types, widths and constants for the Euler-to-quaternion core.
// Holds the CORDIC arctangent table. Depends on nothing.
package e2q_pkg;

    localparam int ANGLE_W        = 16;
    localparam int QUAT_W         = 16;
    localparam int ANGLE_LIMIT    = 25736;
    localparam int QUAT_ONE       = 16384;

    localparam int CORDIC_STAGES  = 14;
    localparam int ATAN_TABLE_LEN = 24;
    localparam int NUM_CELLS      = (CORDIC_STAGES > ATAN_TABLE_LEN) ?
                                    ATAN_TABLE_LEN : CORDIC_STAGES;
    localparam int STAGE_W        = $clog2(ATAN_TABLE_LEN);

    localparam int NUM_AXES       = 3;
    localparam int AXIS_ROLL      = 0;
    localparam int AXIS_PITCH     = 1;
    localparam int AXIS_YAW       = 2;

    // CORDIC datapath: x, y in Q.30, z in units of 2^-28 rad
    localparam int XY_W           = 33;
    localparam int Z_W            = 32;
    localparam int HALF_SHIFT     = 14;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);

    // Product datapath
    localparam int CS_ROUND_SHIFT = 10;
    localparam int CS_W           = 22;
    localparam int PAIR_W         = 2 * CS_W;
    localparam int LO_W           = 21;
    localparam int HI_W           = PAIR_W - LO_W;
    localparam int PH_W           = HI_W + CS_W;
    localparam int PL_W           = LO_W + 1 + CS_W;
    localparam int TRIP_W         = PAIR_W + CS_W;
    localparam int SUM_W          = TRIP_W + 1;
    localparam int ROUND_SHIFT    = 46;
    localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(1) << (ROUND_SHIFT - 1);

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cordic_xyz_t;

    typedef cordic_xyz_t [NUM_AXES-1:0] cordic_vec_t;

    typedef struct packed {
        logic signed [QUAT_W-1:0] w;
        logic signed [QUAT_W-1:0] x;
        logic signed [QUAT_W-1:0] y;
        logic signed [QUAT_W-1:0] z;
    } quat_t;

    // round(atan(2^-i) * 2^28)
    function automatic logic signed [Z_W-1:0] atan_q28(input logic [STAGE_W-1:0] idx);
        unique case (idx)
            0:       atan_q28 = Z_W'(210828714);
            1:       atan_q28 = Z_W'(124459457);
            2:       atan_q28 = Z_W'(65760959);
            3:       atan_q28 = Z_W'(33381290);
            4:       atan_q28 = Z_W'(16755422);
            5:       atan_q28 = Z_W'(8385879);
            6:       atan_q28 = Z_W'(4193963);
            7:       atan_q28 = Z_W'(2097109);
            8:       atan_q28 = Z_W'(1048571);
            9:       atan_q28 = Z_W'(524287);
            10:      atan_q28 = Z_W'(262144);
            11:      atan_q28 = Z_W'(131072);
            12:      atan_q28 = Z_W'(65536);
            13:      atan_q28 = Z_W'(32768);
            14:      atan_q28 = Z_W'(16384);
            15:      atan_q28 = Z_W'(8192);
            16:      atan_q28 = Z_W'(4096);
            17:      atan_q28 = Z_W'(2048);
            18:      atan_q28 = Z_W'(1024);
            19:      atan_q28 = Z_W'(512);
            20:      atan_q28 = Z_W'(256);
            21:      atan_q28 = Z_W'(128);
            22:      atan_q28 = Z_W'(64);
            23:      atan_q28 = Z_W'(32);
            default: atan_q28 = '0;
        endcase
    endfunction

endpackage

@@ design/e2q_angle_if.sv @@
// Input channel: one beat carries roll, pitch and yaw (signed Q3.13 radians).
// Depends on e2q_pkg for field widths.
interface e2q_angle_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [e2q_pkg::ANGLE_W-1:0]   roll;
    logic signed [e2q_pkg::ANGLE_W-1:0]   pitch;
    logic signed [e2q_pkg::ANGLE_W-1:0]   yaw;

    modport source (output valid, output roll, output pitch, output yaw, input ready);
    modport sink   (input valid, input roll, input pitch, input yaw, output ready);
endinterface

@@ design/e2q_quat_if.sv @@
// Output channel: one beat carries a unit quaternion, components signed Q1.14.
// Depends on e2q_pkg for field widths.
interface e2q_quat_if;
    logic                                valid;
    logic                                ready;
    logic signed [e2q_pkg::QUAT_W-1:0]   quat_w;
    logic signed [e2q_pkg::QUAT_W-1:0]   quat_x;
    logic signed [e2q_pkg::QUAT_W-1:0]   quat_y;
    logic signed [e2q_pkg::QUAT_W-1:0]   quat_z;

    modport source (output valid, output quat_w, output quat_x, output quat_y,
                    output quat_z, input ready);
    modport sink   (input valid, input quat_w, input quat_x, input quat_y,
                    input quat_z, output ready);
endinterface

@@ design/euler_to_quaternion_core.sv @@
// ZYX Euler angles to unit quaternion: input register, a chain of CORDIC cells
// (one per stage, 14 by default), then a five-stage product pipeline.
// Throughput: one beat per cycle; the output register plus a one-beat skid
// buffer decouple the sides, and the pipeline holds only while the skid is full.
// Reset (rst_n, async low) clears all valid bits; no clearing pass is needed.
module euler_to_quaternion_core (
    input  logic            clk,
    input  logic            rst_n,
    e2q_angle_if.sink       angles,
    e2q_quat_if.source      quat
);

    // The whole pipeline moves as one; it stops only while the skid holds a
    // beat, which guarantees at most one beat arrives at the end per cycle.
    logic advance;

    // Input register: saturated angles
    logic                                 s0_valid_reg;
    logic signed [e2q_pkg::ANGLE_W-1:0]   s0_angle_reg [e2q_pkg::NUM_AXES];
    logic signed [e2q_pkg::ANGLE_W-1:0]   in_angle     [e2q_pkg::NUM_AXES];
    logic signed [e2q_pkg::ANGLE_W-1:0]   sat_angle    [e2q_pkg::NUM_AXES];

    // CORDIC chain: index 0 is the seed, index NUM_CELLS the last cell output
    logic                  chain_valid [e2q_pkg::NUM_CELLS+1];
    e2q_pkg::cordic_vec_t  chain_data  [e2q_pkg::NUM_CELLS+1];

    logic                  pipe_valid;
    e2q_pkg::quat_t        pipe_data;

    // Output register and skid buffer
    logic                  out_valid_reg;
    e2q_pkg::quat_t        out_data_reg;
    logic                  skid_valid_reg;
    e2q_pkg::quat_t        skid_data_reg;

    assign advance      = !skid_valid_reg;
    assign angles.ready = advance;

    assign in_angle[e2q_pkg::AXIS_ROLL]  = angles.roll;
    assign in_angle[e2q_pkg::AXIS_PITCH] = angles.pitch;
    assign in_angle[e2q_pkg::AXIS_YAW]   = angles.yaw;

    // Clamp to plus or minus pi
    always_comb
    begin
        for (int a = 0; a < e2q_pkg::NUM_AXES; a++)
        begin
            if (in_angle[a] > e2q_pkg::ANGLE_W'(e2q_pkg::ANGLE_LIMIT))
                sat_angle[a] = e2q_pkg::ANGLE_W'(e2q_pkg::ANGLE_LIMIT);
            else if (in_angle[a] < -e2q_pkg::ANGLE_W'(e2q_pkg::ANGLE_LIMIT))
                sat_angle[a] = -e2q_pkg::ANGLE_W'(e2q_pkg::ANGLE_LIMIT);
            else
                sat_angle[a] = in_angle[a];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s0_valid_reg <= angles.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_angle_reg <= sat_angle;
        end
    end

    // CORDIC seed: x = gain, y = 0, z = half angle in 2^-28 rad
    always_comb
    begin
        chain_valid[0] = s0_valid_reg;
        for (int a = 0; a < e2q_pkg::NUM_AXES; a++)
        begin
            chain_data[0][a].x = e2q_pkg::CORDIC_GAIN;
            chain_data[0][a].y = '0;
            chain_data[0][a].z = e2q_pkg::Z_W'(s0_angle_reg[a]) <<< e2q_pkg::HALF_SHIFT;
        end
    end

    for (genvar g = 0; g < e2q_pkg::NUM_CELLS; g++)
    begin : g_cell
        e2q_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .stage     (e2q_pkg::STAGE_W'(g)),
            .valid_in  (chain_valid[g]),
            .data_in   (chain_data[g]),
            .valid_out (chain_valid[g+1]),
            .data_out  (chain_data[g+1])
        );
    end

    e2q_quat_prod u_prod (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .valid_in  (chain_valid[e2q_pkg::NUM_CELLS]),
        .data_in   (chain_data[e2q_pkg::NUM_CELLS]),
        .valid_out (pipe_valid),
        .data_out  (pipe_data)
    );

    // Output side: a finished beat lands in the output register, or in the
    // skid when the output is stalled. The skid drains first.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && !quat.ready)
        begin
            if (pipe_valid && advance)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (skid_valid_reg)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= pipe_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_valid_reg && !quat.ready)
        begin
            if (pipe_valid && advance)
            begin
                skid_data_reg <= pipe_data;
            end
        end
        else if (skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
        else
        begin
            out_data_reg <= pipe_data;
        end
    end

    assign quat.valid  = out_valid_reg;
    assign quat.quat_w = out_data_reg.w;
    assign quat.quat_x = out_data_reg.x;
    assign quat.quat_y = out_data_reg.y;
    assign quat.quat_z = out_data_reg.z;

endmodule

@@ design/e2q_cordic_cell.sv @@
// One CORDIC rotation cell, applied to all three half angles in parallel.
// Depends on e2q_pkg (datapath types, arctangent table).
module e2q_cordic_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic [e2q_pkg::STAGE_W-1:0]   stage,
    input  logic                          valid_in,
    input  e2q_pkg::cordic_vec_t          data_in,
    output logic                          valid_out,
    output e2q_pkg::cordic_vec_t          data_out
);

    logic                  valid_reg;
    e2q_pkg::cordic_vec_t  data_reg;
    e2q_pkg::cordic_vec_t  data_next;

    always_comb
    begin
        logic signed [e2q_pkg::XY_W-1:0] x_cur;
        logic signed [e2q_pkg::XY_W-1:0] y_cur;
        logic signed [e2q_pkg::XY_W-1:0] dx;
        logic signed [e2q_pkg::XY_W-1:0] dy;
        logic signed [e2q_pkg::Z_W-1:0]  z_cur;
        logic signed [e2q_pkg::Z_W-1:0]  angle;
        angle = e2q_pkg::atan_q28(stage);
        for (int a = 0; a < e2q_pkg::NUM_AXES; a++)
        begin
            x_cur = data_in[a].x;
            y_cur = data_in[a].y;
            z_cur = data_in[a].z;
            dx    = y_cur >>> stage;
            dy    = x_cur >>> stage;
            if (!z_cur[e2q_pkg::Z_W-1])
            begin
                data_next[a].x = x_cur - dx;
                data_next[a].y = y_cur + dy;
                data_next[a].z = z_cur - angle;
            end
            else
            begin
                data_next[a].x = x_cur + dx;
                data_next[a].y = y_cur - dy;
                data_next[a].z = z_cur + angle;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

@@ design/e2q_quat_prod.sv @@
// Quaternion product pipeline: rounds CORDIC outputs to sine/cosine, forms
// the triple products in split multiplies and sums them. Depends on e2q_pkg.
module e2q_quat_prod (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  logic                   valid_in,
    input  e2q_pkg::cordic_vec_t   data_in,
    output logic                   valid_out,
    output e2q_pkg::quat_t         data_out
);

    localparam int NUM_PAIRS = 4;
    localparam int NUM_TERMS = 8;
    localparam int NUM_COMP  = 4;
    localparam int P_CC = 0;   // cr*cp
    localparam int P_SS = 1;   // sr*sp
    localparam int P_SC = 2;   // sr*cp
    localparam int P_CS = 3;   // cr*sp

    // stage valids
    logic v_round_reg, v_pair_reg, v_part_reg, v_trip_reg, v_sum_reg;

    // rounded cosine / sine per axis
    logic signed [e2q_pkg::CS_W-1:0] cos_reg [e2q_pkg::NUM_AXES];
    logic signed [e2q_pkg::CS_W-1:0] sin_reg [e2q_pkg::NUM_AXES];
    logic signed [e2q_pkg::CS_W-1:0] cos_next [e2q_pkg::NUM_AXES];
    logic signed [e2q_pkg::CS_W-1:0] sin_next [e2q_pkg::NUM_AXES];

    // roll/pitch pair products, yaw terms carried alongside
    logic signed [e2q_pkg::PAIR_W-1:0] pair_reg [NUM_PAIRS];
    logic signed [e2q_pkg::CS_W-1:0]   cy_reg, sy_reg;

    // partial products of each triple
    logic signed [e2q_pkg::PH_W-1:0]   ph_reg  [NUM_TERMS];
    logic signed [e2q_pkg::PL_W-1:0]   pl_reg  [NUM_TERMS];
    logic signed [e2q_pkg::PH_W-1:0]   ph_next [NUM_TERMS];
    logic signed [e2q_pkg::PL_W-1:0]   pl_next [NUM_TERMS];

    logic signed [e2q_pkg::TRIP_W-1:0] trip_reg [NUM_TERMS];
    logic signed [e2q_pkg::SUM_W-1:0]  sum_reg  [NUM_COMP];
    logic signed [e2q_pkg::QUAT_W-1:0] comp     [NUM_COMP];

    always_comb
    begin
        logic signed [e2q_pkg::XY_W:0] rx;
        logic signed [e2q_pkg::XY_W:0] ry;
        logic signed [e2q_pkg::XY_W:0] sx;
        logic signed [e2q_pkg::XY_W:0] sy;
        for (int a = 0; a < e2q_pkg::NUM_AXES; a++)
        begin
            rx = (e2q_pkg::XY_W+1)'(data_in[a].x) + (e2q_pkg::XY_W+1)'(512);
            ry = (e2q_pkg::XY_W+1)'(data_in[a].y) + (e2q_pkg::XY_W+1)'(512);
            sx = rx >>> e2q_pkg::CS_ROUND_SHIFT;
            sy = ry >>> e2q_pkg::CS_ROUND_SHIFT;
            cos_next[a] = sx[e2q_pkg::CS_W-1:0];
            sin_next[a] = sy[e2q_pkg::CS_W-1:0];
        end
    end

    // Triple k = pair[term_pair[k]] * third; hi/lo split of the pair keeps
    // each multiplier near 23x22.
    always_comb
    begin
        logic signed [e2q_pkg::PAIR_W-1:0] tp   [NUM_TERMS];
        logic signed [e2q_pkg::CS_W-1:0]   th   [NUM_TERMS];
        logic signed [e2q_pkg::HI_W-1:0]   hi;
        logic signed [e2q_pkg::LO_W:0]     lo;
        tp[0] = pair_reg[P_CC]; th[0] = cy_reg;   // w
        tp[1] = pair_reg[P_SS]; th[1] = sy_reg;
        tp[2] = pair_reg[P_SC]; th[2] = cy_reg;   // x
        tp[3] = pair_reg[P_CS]; th[3] = sy_reg;
        tp[4] = pair_reg[P_CS]; th[4] = cy_reg;   // y
        tp[5] = pair_reg[P_SC]; th[5] = sy_reg;
        tp[6] = pair_reg[P_CC]; th[6] = sy_reg;   // z
        tp[7] = pair_reg[P_SS]; th[7] = cy_reg;
        for (int k = 0; k < NUM_TERMS; k++)
        begin
            hi = tp[k][e2q_pkg::PAIR_W-1:e2q_pkg::LO_W];
            lo = {1'b0, tp[k][e2q_pkg::LO_W-1:0]};
            ph_next[k] = hi * th[k];
            pl_next[k] = lo * th[k];
        end
    end

    always_comb
    begin
        logic signed [e2q_pkg::SUM_W-1:0] r;
        for (int c = 0; c < NUM_COMP; c++)
        begin
            r = sum_reg[c] >>> e2q_pkg::ROUND_SHIFT;
            if (r > e2q_pkg::SUM_W'(e2q_pkg::QUAT_ONE))
                comp[c] = e2q_pkg::QUAT_W'(e2q_pkg::QUAT_ONE);
            else if (r < -e2q_pkg::SUM_W'(e2q_pkg::QUAT_ONE))
                comp[c] = -e2q_pkg::QUAT_W'(e2q_pkg::QUAT_ONE);
            else
                comp[c] = r[e2q_pkg::QUAT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_round_reg <= 1'b0;
            v_pair_reg  <= 1'b0;
            v_part_reg  <= 1'b0;
            v_trip_reg  <= 1'b0;
            v_sum_reg   <= 1'b0;
        end
        else if (advance)
        begin
            v_round_reg <= valid_in;
            v_pair_reg  <= v_round_reg;
            v_part_reg  <= v_pair_reg;
            v_trip_reg  <= v_part_reg;
            v_sum_reg   <= v_trip_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;

            pair_reg[P_CC] <= cos_reg[e2q_pkg::AXIS_ROLL] * cos_reg[e2q_pkg::AXIS_PITCH];
            pair_reg[P_SS] <= sin_reg[e2q_pkg::AXIS_ROLL] * sin_reg[e2q_pkg::AXIS_PITCH];
            pair_reg[P_SC] <= sin_reg[e2q_pkg::AXIS_ROLL] * cos_reg[e2q_pkg::AXIS_PITCH];
            pair_reg[P_CS] <= cos_reg[e2q_pkg::AXIS_ROLL] * sin_reg[e2q_pkg::AXIS_PITCH];
            cy_reg         <= cos_reg[e2q_pkg::AXIS_YAW];
            sy_reg         <= sin_reg[e2q_pkg::AXIS_YAW];

            ph_reg <= ph_next;
            pl_reg <= pl_next;

            for (int k = 0; k < NUM_TERMS; k++)
            begin
                trip_reg[k] <= (e2q_pkg::TRIP_W'(ph_reg[k]) <<< e2q_pkg::LO_W)
                             + e2q_pkg::TRIP_W'(pl_reg[k]);
            end

            sum_reg[0] <= e2q_pkg::SUM_W'(trip_reg[0]) + e2q_pkg::SUM_W'(trip_reg[1])
                        + e2q_pkg::ROUND_BIAS;
            sum_reg[1] <= e2q_pkg::SUM_W'(trip_reg[2]) - e2q_pkg::SUM_W'(trip_reg[3])
                        + e2q_pkg::ROUND_BIAS;
            sum_reg[2] <= e2q_pkg::SUM_W'(trip_reg[4]) + e2q_pkg::SUM_W'(trip_reg[5])
                        + e2q_pkg::ROUND_BIAS;
            sum_reg[3] <= e2q_pkg::SUM_W'(trip_reg[6]) - e2q_pkg::SUM_W'(trip_reg[7])
                        + e2q_pkg::ROUND_BIAS;
        end
    end

    assign valid_out  = v_sum_reg;
    assign data_out.w = comp[0];
    assign data_out.x = comp[1];
    assign data_out.y = comp[2];
    assign data_out.z = comp[3];

endmodule

@@ design/e2q_checker.sv @@
// Port-level checks for euler_to_quaternion_core, with the bind that attaches them.
// Depends on e2q_pkg and on the top level's interface ports.
module e2q_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_ready,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic signed [e2q_pkg::QUAT_W-1:0]  quat_w,
    input  logic signed [e2q_pkg::QUAT_W-1:0]  quat_x,
    input  logic signed [e2q_pkg::QUAT_W-1:0]  quat_y,
    input  logic signed [e2q_pkg::QUAT_W-1:0]  quat_z
);

    localparam int NORM_W   = 2 * e2q_pkg::QUAT_W + 2;
    localparam int NORM_ONE = e2q_pkg::QUAT_ONE * e2q_pkg::QUAT_ONE;
    localparam int NORM_TOL = 1 << 21;

    logic signed [NORM_W-1:0] norm;

    assign norm = NORM_W'(quat_w) * NORM_W'(quat_w) + NORM_W'(quat_x) * NORM_W'(quat_x)
                + NORM_W'(quat_y) * NORM_W'(quat_y) + NORM_W'(quat_z) * NORM_W'(quat_z);

    // A stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(quat_w) && $stable(quat_x)
                                    && $stable(quat_y) && $stable(quat_z))
        else $error("stalled output beat changed");

    // Input backpressure only follows a stalled output
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> $past(out_valid && !out_ready))
        else $error("input stalled without an output stall");

    // Components stay within plus or minus one
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> quat_w <= e2q_pkg::QUAT_ONE && quat_w >= -e2q_pkg::QUAT_ONE
                   && quat_x <= e2q_pkg::QUAT_ONE && quat_x >= -e2q_pkg::QUAT_ONE
                   && quat_y <= e2q_pkg::QUAT_ONE && quat_y >= -e2q_pkg::QUAT_ONE
                   && quat_z <= e2q_pkg::QUAT_ONE && quat_z >= -e2q_pkg::QUAT_ONE)
        else $error("quaternion component out of range");

    // Output is a unit quaternion within rounding and CORDIC error
    a_unit_norm: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> norm <= NORM_W'(NORM_ONE + NORM_TOL)
                   && norm >= NORM_W'(NORM_ONE - NORM_TOL))
        else $error("quaternion norm far from one");

endmodule

bind euler_to_quaternion_core e2q_checker u_e2q_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (angles.ready),
    .out_valid (quat.valid),
    .out_ready (quat.ready),
    .quat_w    (quat.quat_w),
    .quat_x    (quat.quat_x),
    .quat_y    (quat.quat_y),
    .quat_z    (quat.quat_z)
);
